// ===== rtl/core/ate_pkg.sv =====
// ----------------------------------------------------------------------------
// ate_pkg
// Shared types for the array table engine: operation and status codes and
// the command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ate_pkg;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_DEL_ORD = 3'd1,
    OP_DEL_SWP = 3'd2,
    OP_FIND    = 3'd3,
    OP_COUNT   = 3'd4,
    OP_DEL_ALL = 3'd5,
    OP_READ    = 3'd6,
    OP_NOP     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch the request and plan the walk
    logic scan;    // issue the next table read
    logic commit;  // final write, length update, load the result word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic reads_done;
  } stat_t;

endpackage

// ===== rtl/core/ate_intf.sv =====
// ----------------------------------------------------------------------------
// ate_req_if / ate_rsp_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface ate_req_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  kind;
  logic        [8:0]  position;
  logic signed [31:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface ate_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic        [7:0]  found_index;
  logic        [8:0]  tally;
  logic signed [31:0] read_value;

  modport source (output valid, status, found_index, tally, read_value, input ready);
  modport sink   (input valid, status, found_index, tally, read_value, output ready);
endinterface

// ===== rtl/core/ate_ctrl.sv =====
// ----------------------------------------------------------------------------
// ate_ctrl
// Request sequencer: accept a word, walk the table, then hand the result
// to the output register once it is free.
// ----------------------------------------------------------------------------
module ate_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  ate_pkg::stat_t stat_i,
  output ate_pkg::cmd_t  cmd_o
);
  import ate_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   rsp_valid_q;
  logic   slot_free;

  assign slot_free   = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = ready_q;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && req_valid_i && ready_q;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.commit = (state_q == S_FINISH) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      // load a new result word, or drop the current one once taken
      if ((state_q == S_FINISH) && slot_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i && ready_q) begin
            ready_q <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat_i.reads_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            ready_q     <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/ate_dpath.sv =====
// ----------------------------------------------------------------------------
// ate_dpath
// Table memory, length register, walk pointers and result register.
// ----------------------------------------------------------------------------
module ate_dpath #(
  parameter int unsigned DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ate_pkg::cmd_t      cmd_i,
  output ate_pkg::stat_t     stat_o,
  input  logic        [2:0]  req_kind_i,
  input  logic        [8:0]  req_position_i,
  input  logic signed [31:0] req_value_i,
  output logic        [1:0]  rsp_status_o,
  output logic        [7:0]  rsp_found_index_o,
  output logic        [8:0]  rsp_tally_o,
  output logic signed [31:0] rsp_read_value_o
);
  import ate_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (LW > 9) ? LW : 9;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [31:0] mem [DEPTH];

  op_e         op_q;
  logic [CW-1:0] pos_q;
  logic [31:0] val_q;
  status_e     st_q;
  logic [LW-1:0] len_q;
  logic [AW-1:0] rd_ptr_q;
  logic [LW-1:0] rd_cnt_q;
  logic        down_q;
  logic        rv_q;
  logic [AW-1:0] rv_addr_q;
  logic [31:0] rdata_q;
  logic [LW-1:0] wr_ptr_q;
  logic [LW-1:0] cnt_q;
  logic        hit_q;
  logic [AW-1:0] found_q;
  logic [31:0] rdval_q;

  logic [1:0]  rsp_status_q;
  logic [7:0]  rsp_found_index_q;
  logic [8:0]  rsp_tally_q;
  logic [31:0] rsp_read_value_q;

  // request plan
  op_e           op_c;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] len_c;
  logic [CW-1:0] len_m1_c;
  logic [CW-1:0] pos_p1_c;
  status_e       st_c;
  logic [CW-1:0] cnt_c;
  logic [CW-1:0] ptr_c;
  logic          down_c;

  always_comb begin
    op_c     = op_e'(req_kind_i);
    pos_c    = CW'(req_position_i);
    len_c    = CW'(len_q);
    len_m1_c = len_c - CW'(1);
    pos_p1_c = pos_c + CW'(1);
    st_c     = ST_OK;
    cnt_c    = '0;
    ptr_c    = '0;
    down_c   = 1'b0;
    unique case (op_c)
      OP_INSERT: begin
        if (len_c == DEPTH_C) begin
          st_c = ST_FULL;
        end else if (pos_c > len_c) begin
          st_c = ST_BADPOS;
        end else begin
          cnt_c  = len_c - pos_c;
          ptr_c  = len_m1_c;
          down_c = 1'b1;
        end
      end
      OP_DEL_ORD: begin
        if (pos_c >= len_c) begin
          st_c = ST_BADPOS;
        end else begin
          cnt_c = len_m1_c - pos_c;
          ptr_c = pos_p1_c;
        end
      end
      OP_DEL_SWP: begin
        if (pos_c >= len_c) begin
          st_c = ST_BADPOS;
        end else begin
          cnt_c = CW'(1);
          ptr_c = len_m1_c;
        end
      end
      OP_FIND, OP_COUNT, OP_DEL_ALL: begin
        cnt_c = len_c;
      end
      OP_READ: begin
        if (pos_c >= len_c) begin
          st_c = ST_BADPOS;
        end else begin
          cnt_c = CW'(1);
          ptr_c = pos_c;
        end
      end
      default: begin
        st_c = ST_OK;
      end
    endcase
  end

  assign stat_o.reads_done = (rd_cnt_q == '0);

  // write port: shift/compact from the read pipe, or the final insert
  logic          match;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  assign match = (rdata_q == val_q);

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rdata_q;
    if (rv_q) begin
      case (op_q)
        OP_INSERT: begin
          we = 1'b1;
          wa = rv_addr_q + AW'(1);
        end
        OP_DEL_ORD: begin
          we = 1'b1;
          wa = rv_addr_q - AW'(1);
        end
        OP_DEL_SWP: begin
          we = 1'b1;
          wa = pos_q[AW-1:0];
        end
        OP_DEL_ALL: begin
          we = !match;
          wa = wr_ptr_q[AW-1:0];
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end else if (cmd_i.commit && (op_q == OP_INSERT) && (st_q == ST_OK)) begin
      we = 1'b1;
      wa = pos_q[AW-1:0];
      wd = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[rd_ptr_q];
  end

  // result word
  logic [LW-1:0] new_len;
  logic [CW-1:0] tally_c;
  logic [CW-1:0] found_c;
  status_e       st_fin;

  always_comb begin
    new_len = len_q;
    case (op_q)
      OP_INSERT:              if (st_q == ST_OK) new_len = len_q + LW'(1);
      OP_DEL_ORD, OP_DEL_SWP: if (st_q == ST_OK) new_len = len_q - LW'(1);
      OP_DEL_ALL:             new_len = wr_ptr_q;
      default:                new_len = len_q;
    endcase
    if ((op_q == OP_COUNT) || (op_q == OP_DEL_ALL)) begin
      tally_c = CW'(cnt_q);
    end else begin
      tally_c = CW'(new_len);
    end
    found_c = ((op_q == OP_FIND) && hit_q) ? CW'(found_q) : '0;
    st_fin  = ((op_q == OP_FIND) && !hit_q) ? ST_NOTFOUND : st_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      rd_cnt_q <= '0;
      rv_q     <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_cnt_q <= cnt_c[LW-1:0];
        rv_q     <= 1'b0;
      end else if (cmd_i.scan && (rd_cnt_q != '0)) begin
        rd_cnt_q <= rd_cnt_q - LW'(1);
        rv_q     <= 1'b1;
      end else begin
        rv_q     <= 1'b0;
      end
      if (cmd_i.commit) begin
        len_q <= new_len;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_c;
      pos_q    <= pos_c;
      val_q    <= req_value_i;
      st_q     <= st_c;
      rd_ptr_q <= ptr_c[AW-1:0];
      down_q   <= down_c;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
      hit_q    <= 1'b0;
      found_q  <= '0;
      rdval_q  <= '0;
    end else begin
      if (cmd_i.scan && (rd_cnt_q != '0)) begin
        rv_addr_q <= rd_ptr_q;
        rd_ptr_q  <= down_q ? (rd_ptr_q - AW'(1)) : (rd_ptr_q + AW'(1));
      end
      if (rv_q) begin
        case (op_q)
          OP_FIND: begin
            if (match && !hit_q) begin
              hit_q   <= 1'b1;
              found_q <= rv_addr_q;
            end
          end
          OP_COUNT: begin
            if (match) cnt_q <= cnt_q + LW'(1);
          end
          OP_DEL_ALL: begin
            if (match) begin
              cnt_q <= cnt_q + LW'(1);
            end else begin
              wr_ptr_q <= wr_ptr_q + LW'(1);
            end
          end
          OP_READ: begin
            rdval_q <= rdata_q;
          end
          default: begin
            rdval_q <= rdval_q;
          end
        endcase
      end
    end
    if (cmd_i.commit) begin
      rsp_status_q      <= st_fin;
      rsp_found_index_q <= found_c[7:0];
      rsp_tally_q       <= tally_c[8:0];
      rsp_read_value_q  <= ((op_q == OP_READ) && (st_q == ST_OK)) ? rdval_q : '0;
    end
  end

  assign rsp_status_o      = rsp_status_q;
  assign rsp_found_index_o = rsp_found_index_q;
  assign rsp_tally_o       = rsp_tally_q;
  assign rsp_read_value_o  = rsp_read_value_q;

endmodule

// ===== rtl/core/array_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// array_table_engine_top
// Packed table of signed 32-bit words with insert, delete, search, count
// and read requests.
// ----------------------------------------------------------------------------
// One request is in flight at a time and yields exactly one result word.
// A request makes N table reads between acceptance and its result, where
// N is the number of table reads it needs: length - position for insert,
// length - position - 1 for ordered delete, 1 for swap-last delete and
// read, the full length for find, count and delete-all, and 0 for rejected
// requests and the unused kind. The table memory has a single read port,
// which walks one entry per cycle. If the previous result word is still
// waiting in the output register, the finished request holds until it is
// taken. The table itself is not cleared at reset; only its length is, so
// no entry is ever seen before it was written. A finished result waits in
// an output register, and the next request is taken while it waits.
// ----------------------------------------------------------------------------
module array_table_engine_top #(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ate_req_if.sink     req_i,
  ate_rsp_if.source   rsp_o
);
  import ate_pkg::*;

  cmd_t  cmd;   // controller commands to the datapath
  stat_t stat;  // walk progress back to the controller

  // Sequencer: holds the handshake state and steps the walk.
  ate_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: table memory, length, pointers and the result word.
  ate_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_kind_i        (req_i.kind),
    .req_position_i    (req_i.position),
    .req_value_i       (req_i.value),
    .rsp_status_o      (rsp_o.status),
    .rsp_found_index_o (rsp_o.found_index),
    .rsp_tally_o       (rsp_o.tally),
    .rsp_read_value_o  (rsp_o.read_value)
  );

endmodule

// ===== rtl/core/ate_checker.sv =====
// ----------------------------------------------------------------------------
// ate_checker
// Port-level checks for the array table engine, bound to the top level.
// ----------------------------------------------------------------------------
module ate_checker #(
  parameter int unsigned DEPTH = 256
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  rsp_status_i,
  input logic [7:0]  rsp_found_index_i,
  input logic [8:0]  rsp_tally_i,
  input logic [31:0] rsp_read_value_i
);
  import ate_pkg::*;

  localparam logic [8:0] FULL_TALLY = 9'(DEPTH);

  // stalled result word holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_found_index_i) && $stable(rsp_tally_i)
      && $stable(rsp_read_value_i))
    else $error("result word changed while stalled");

  // one request at a time
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in flight");

  // no result in the cycle right after an accept
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_valid_i && req_ready_i))
    else $error("result appeared too early");

  // index and read data only on success
  a_fields_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && ((rsp_found_index_i != '0) || (rsp_read_value_i != '0))
      |-> rsp_status_i == ST_OK)
    else $error("index or read data set on a failed request");

  // full table reports the full length
  a_full_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_FULL) |-> rsp_tally_i == FULL_TALLY)
    else $error("full status with wrong length");

endmodule

bind array_table_engine_top ate_checker #(
  .DEPTH (DEPTH)
) u_ate_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_found_index_i (rsp_o.found_index),
  .rsp_tally_i       (rsp_o.tally),
  .rsp_read_value_i  (rsp_o.read_value)
);

// ===== test/tb_array_table_engine_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_array_table_engine_top
// Self-checking bench for the array table engine. Requests are driven on the
// request channel and every reply word is compared against a shadow copy of
// the table that is updated as each request word is accepted. A short
// directed run covers empty-table and boundary cases. Random traffic then
// fills the table to capacity and mixes all operations. Both channel sides
// idle at random, and the reply side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_array_table_engine_top;
  import ate_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned TOTAL_REQS  = 750;
  localparam int unsigned STALL_LIMIT = 5000;   // cycles without any word accepted
  localparam int unsigned DRAIN_WAIT  = 300;    // longer than the longest walk
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AT     = 150;    // request count that triggers the hold

  typedef struct {
    logic [1:0]         status;
    logic [7:0]         found_index;
    logic [8:0]         tally;
    logic signed [31:0] read_value;
  } reply_t;

  // Shadow of the table contents; it predicts one reply per request word.
  class reply_scoreboard;
    logic signed [31:0] words [TABLE_DEPTH];
    int unsigned        fill;
    int unsigned        peak_fill;
    reply_t             pending_replies [$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        status_seen [4];

    function new();
      fill       = 0;
      peak_fill  = 0;
      mismatches = 0;
      checked    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Apply one accepted request to the shadow and queue its reply.
    function void note_request(op_e op, logic [8:0] pos, logic signed [31:0] key);
      reply_t      r;
      int unsigned i;
      int unsigned w;
      int unsigned hits;
      r.status      = ST_OK;
      r.found_index = 8'd0;
      r.tally       = 9'(fill);
      r.read_value  = 32'sd0;
      case (op)
        OP_INSERT: begin
          if (fill >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else if (pos > fill) begin
            r.status = ST_BADPOS;
          end else begin
            for (i = fill; i > pos; i--) words[i] = words[i-1];
            words[pos] = key;
            fill++;
            r.tally = 9'(fill);
          end
        end
        OP_DEL_ORD: begin
          if (pos >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            for (i = pos; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
            r.tally = 9'(fill);
          end
        end
        OP_DEL_SWP: begin
          if (pos >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            words[pos] = words[fill-1];
            fill--;
            r.tally = 9'(fill);
          end
        end
        OP_FIND: begin
          for (i = 0; i < fill; i++) if (words[i] == key) break;
          if (i < fill) r.found_index = 8'(i);
          else r.status = ST_NOTFOUND;
        end
        OP_COUNT: begin
          hits = 0;
          for (i = 0; i < fill; i++) if (words[i] == key) hits++;
          r.tally = 9'(hits);
        end
        OP_DEL_ALL: begin
          hits = 0;
          w    = 0;
          for (i = 0; i < fill; i++) begin
            if (words[i] == key) hits++;
            else begin
              words[w] = words[i];
              w++;
            end
          end
          fill    = w;
          r.tally = 9'(hits);
        end
        OP_READ: begin
          if (pos >= fill) r.status = ST_BADPOS;
          else r.read_value = words[pos];
        end
        default: ;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      pending_replies.push_back(r);
    endfunction

    // Compare one reply word with the oldest queued prediction.
    function void check_reply(logic [1:0] status, logic [7:0] found_index,
                              logic [8:0] tally, logic signed [31:0] read_value);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected reply: status %0d index %0d tally %0d value %0d",
                   $realtime, status, found_index, tally, read_value);
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      status_seen[status]++;
      if (status !== want.status || found_index !== want.found_index ||
          tally !== want.tally || read_value !== want.read_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] reply %0d mismatch: status %0d/%0d index %0d/%0d ",
                    "tally %0d/%0d value %0d/%0d (expected/actual)"},
                   $realtime, checked, want.status, status, want.found_index,
                   found_index, want.tally, tally, want.read_value, read_value);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ate_req_if req_ch ();
  ate_rsp_if rsp_ch ();

  array_table_engine_top #(
    .DEPTH (TABLE_DEPTH)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  reply_scoreboard sb;
  int unsigned     n_sent;
  int unsigned     stall_count;
  bit              holdoff_done;

  // Keys that repeat often, so searches and counts see several hits.
  logic signed [31:0] key_pool [8] = '{
    32'sd0, -32'sd1, 32'sh7fffffff, 32'sh80000000,
    32'sd1, 32'sd5, 32'sh5a5a5a5a, -32'sd100
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Quiet window: neither side idles while these requests go through.
  function automatic bit idle_free();
    return n_sent >= 420 && n_sent < 540;
  endfunction

  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return key_pool[$urandom_range(0, 7)];
  endfunction

  // Drive one request word and hold it until the block takes it. Drive at
  // the falling edge, sample ready at the rising edge.
  task automatic issue_request(op_e op, logic [8:0] pos, logic signed [31:0] key);
    @(negedge clk);
    if (!idle_free() && $urandom_range(0, 99) < 6) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= op;
    req_ch.position <= pos;
    req_ch.value    <= key;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, pos, key);
    n_sent++;
  endtask

  // Build one random request. While filling, favor inserts and skip deletes
  // so the table climbs to capacity; otherwise mix every kind.
  task automatic random_request(bit filling);
    op_e                op;
    logic [8:0]         pos;
    logic signed [31:0] key;
    int unsigned        roll;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 88) op = OP_INSERT;
      else begin
        case ($urandom_range(0, 3))
          0:       op = OP_FIND;
          1:       op = OP_COUNT;
          2:       op = OP_READ;
          default: op = OP_NOP;
        endcase
      end
    end else begin
      if (roll < 30)      op = OP_INSERT;
      else if (roll < 42) op = OP_DEL_ORD;
      else if (roll < 52) op = OP_DEL_SWP;
      else if (roll < 64) op = OP_FIND;
      else if (roll < 76) op = OP_COUNT;
      else if (roll < 82) op = OP_DEL_ALL;
      else if (roll < 96) op = OP_READ;
      else                op = OP_NOP;
    end
    // Mostly legal positions, with some anywhere from 0 up to the table depth.
    if ($urandom_range(0, 99) < 12) pos = 9'($urandom_range(0, TABLE_DEPTH));
    else if (op == OP_INSERT)       pos = 9'($urandom_range(0, sb.fill));
    else if (sb.fill > 0)           pos = 9'($urandom_range(0, sb.fill - 1));
    else                            pos = 9'd0;
    // Search keys are usually taken from the table itself to force hits.
    if (op != OP_INSERT && sb.fill > 0 && $urandom_range(0, 3) != 0)
      key = sb.words[$urandom_range(0, sb.fill - 1)];
    else
      key = pick_key();
    issue_request(op, pos, key);
  endtask

  // Reply side: ready drops at random, 6 in 100, never in the quiet window,
  // and once holds low for a long stretch so the block backs up and stalls
  // its request side.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!holdoff_done && n_sent >= HOLD_AT) begin
        holdoff_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        rsp_ch.ready <= idle_free() || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  // Check every reply word taken at the rising edge.
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      sb.check_reply(rsp_ch.status, rsp_ch.found_index, rsp_ch.tally, rsp_ch.read_value);
  end

  // Watchdog: count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        stall_count <= 0;
      else
        stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("[%0t] timeout: no word accepted for %0d cycles", $realtime, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    sb              = new();
    n_sent          = 0;
    stall_count     = 0;
    holdoff_done    = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.kind     = OP_NOP;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table: every positional request is rejected, searches miss.
    issue_request(OP_READ,    9'd0,   32'sd0);
    issue_request(OP_DEL_ORD, 9'd0,   32'sd0);
    issue_request(OP_DEL_SWP, 9'd0,   32'sd0);
    issue_request(OP_FIND,    9'd0,   32'sd0);
    issue_request(OP_COUNT,   9'd0,   32'sd0);
    issue_request(OP_DEL_ALL, 9'd0,   32'sd0);
    issue_request(OP_INSERT,  9'd1,   32'sd7);            // beyond length
    // Build a small table with the extreme words and a duplicate.
    issue_request(OP_INSERT,  9'd0,   32'sh7fffffff);
    issue_request(OP_INSERT,  9'd1,   32'sh80000000);     // append at length
    issue_request(OP_INSERT,  9'd0,   -32'sd1);           // shift everything up
    issue_request(OP_INSERT,  9'd1,   32'sh7fffffff);
    issue_request(OP_FIND,    9'd0,   32'sh7fffffff);
    issue_request(OP_FIND,    9'd0,   32'sd12345);        // miss
    issue_request(OP_COUNT,   9'd0,   32'sh7fffffff);
    issue_request(OP_READ,    9'd3,   32'sd0);
    issue_request(OP_READ,    9'd256, 32'sd0);            // position equal to the table depth
    issue_request(OP_INSERT,  9'd256, -32'sd5);
    issue_request(OP_NOP,     9'd256, 32'sh5a5a5a5a);     // unused kind
    issue_request(OP_DEL_ORD, 9'd1,   32'sd0);
    issue_request(OP_DEL_SWP, 9'd0,   32'sd0);
    issue_request(OP_INSERT,  9'd0,   32'sh7fffffff);
    issue_request(OP_DEL_ALL, 9'd0,   32'sh7fffffff);     // includes the last entry
    issue_request(OP_READ,    9'd0,   32'sd0);
    issue_request(OP_DEL_ORD, 9'(sb.fill - 1), 32'sd0);   // last entry

    // Fill to capacity, then push a few more inserts against a full table.
    while (sb.fill < TABLE_DEPTH) random_request(1'b1);
    repeat (3) issue_request(OP_INSERT, 9'($urandom_range(0, TABLE_DEPTH)), pick_key());
    // Mixed traffic for the rest of the run.
    while (n_sent < TOTAL_REQS) random_request(1'b0);

    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Drain: wait for every reply, then allow one full walk for stragglers.
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests over all eight kinds; table peaked at %0d of %0d entries.",
             n_sent, sb.peak_fill, TABLE_DEPTH);
    $display("Checked %0d replies (ok %0d, full %0d, bad position %0d, not found %0d), %0d bad.",
             sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
             sb.status_seen[ST_BADPOS], sb.status_seen[ST_NOTFOUND], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
